// ----- rtl/rfbs_pkg.sv -----
// Package for the reply frame boundary scanner: parameter defaults, byte codes,
// parse phase and controller state types, and the controller/datapath structs.
// No dependencies.
package rfbs_pkg;

    localparam int MAX_NEST_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF     = 32;
    localparam int FRAME_BITS         = 32;
    localparam int ERR_BITS           = 2;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_BULK   = 8'h24;   // '$'
    localparam logic [7:0] CHAR_VERB   = 8'h3D;   // '='
    localparam logic [7:0] CHAR_ARRAY  = 8'h2A;   // '*'
    localparam logic [7:0] CHAR_SET    = 8'h7E;   // '~'
    localparam logic [7:0] CHAR_PUSH   = 8'h3E;   // '>'
    localparam logic [7:0] CHAR_MAP    = 8'h25;   // '%'
    localparam logic [7:0] CHAR_ATTR   = 8'h7C;   // '|'

    localparam logic [ERR_BITS-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_NEST     = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_HEADER   = 2'd2;
    localparam logic [ERR_BITS-1:0] ERR_FRAME    = 2'd3;

    localparam logic [1:0] KIND_BULK  = 2'd0;
    localparam logic [1:0] KIND_ARRAY = 2'd1;
    localparam logic [1:0] KIND_MAP   = 2'd2;
    localparam logic [1:0] KIND_ATTR  = 2'd3;

    typedef enum logic [2:0] {
        PH_TYPE      = 3'd0,
        PH_LINE      = 3'd1,
        PH_HDR_FIRST = 3'd2,
        PH_HDR_REST  = 3'd3,
        PH_PAYLOAD   = 3'd4
    } phase_t;

    typedef enum logic [0:0] {
        CTRL_RUN   = 1'b0,
        CTRL_CLOSE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic take_byte;
        logic close_step;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic cascade_req;
        logic depth_zero;
        logic close_last;
    } dp_status_t;

endpackage

// ----- rtl/rfbs_datapath.sv -----
// Datapath of the frame boundary scanner: parse phase, header number, payload
// counter, nesting stack, frame byte count and result registers.
// Depends on rfbs_pkg; driven by rfbs_controller.
module rfbs_datapath import rfbs_pkg::*; #(
    parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_data_byte,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [FRAME_BITS-1:0] m_frame_length,
    output logic [ERR_BITS-1:0]   m_error_code
);

    localparam int DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);
    localparam int IDX_W   = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
    localparam int OWE_W   = COUNT_BITS + 1;
    localparam int PROD_W  = COUNT_BITS + 4;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             kind_reg, kind_next;
    logic                   hneg_reg, hneg_next;
    logic [COUNT_BITS-1:0]  hval_reg, hval_next;
    logic                   dend_reg, dend_next;
    logic                   pcr_reg, pcr_next;
    logic [OWE_W-1:0]       pay_reg, pay_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [FRAME_BITS-1:0]  fcount_reg, fcount_next;
    logic [FRAME_BITS-1:0]  len_reg, len_next;
    logic [ERR_BITS-1:0]    err_reg, err_next;
    logic [OWE_W-1:0]       stack_reg [MAX_NEST_DEPTH];

    logic                   stack_we;
    logic [IDX_W-1:0]       stack_waddr;
    logic [OWE_W-1:0]       stack_wdata;

    logic [DEPTH_W-1:0]     top_full;
    logic [IDX_W-1:0]       top_idx;
    logic [OWE_W-1:0]       top_owed;
    logic [OWE_W-1:0]       top_dec;
    logic [FRAME_BITS-1:0]  fcnt_inc;
    logic                   digit;
    logic [3:0]             dval;
    logic [PROD_W-1:0]      prod;
    logic [OWE_W-1:0]       owed;
    logic [OWE_W-1:0]       pay_dec;
    logic                   depth_zero;

    logic                   elem_done;
    logic                   err_hit;
    logic                   restart_now;
    logic [ERR_BITS-1:0]    err_sel;
    logic                   emit;
    logic                   cascade_req;

    assign top_full   = depth_reg - DEPTH_W'(1);
    assign top_idx    = top_full[IDX_W-1:0];
    assign top_owed   = stack_reg[top_idx];
    assign top_dec    = top_owed - OWE_W'(1);
    assign depth_zero = (depth_reg == '0);
    assign fcnt_inc   = fcount_reg + FRAME_BITS'(1);
    assign digit      = (s_data_byte >= CHAR_0) && (s_data_byte <= CHAR_9);
    assign dval       = digit ? s_data_byte[3:0] : 4'd0;
    // Times ten plus the digit, as two shifts and two adds; any bit from COUNT_BITS up is an overflow.
    assign prod       = ({4'b0, hval_reg} << 3) + ({4'b0, hval_reg} << 1)
                        + PROD_W'(dval);
    assign pay_dec    = (pay_reg != '0) ? (pay_reg - OWE_W'(1)) : pay_reg;

    always_comb begin
        unique case (kind_reg)
            KIND_ARRAY: owed = {1'b0, hval_reg};
            KIND_MAP:   owed = {hval_reg, 1'b0};
            KIND_ATTR:  owed = {hval_reg, 1'b1};
            default:    owed = '0;
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        hneg_next   = hneg_reg;
        hval_next   = hval_reg;
        dend_next   = dend_reg;
        pcr_next    = pcr_reg;
        pay_next    = pay_reg;
        depth_next  = depth_reg;
        fcount_next = fcount_reg;
        len_next    = len_reg;
        err_next    = err_reg;
        stack_we    = 1'b0;
        stack_waddr = top_idx;
        stack_wdata = top_dec;
        elem_done   = 1'b0;
        err_hit     = 1'b0;
        restart_now = 1'b0;
        err_sel     = ERR_OK;
        emit        = 1'b0;
        cascade_req = 1'b0;

        if (cmd.take_byte) begin
            if (fcount_reg == '1) begin
                err_hit = 1'b1;
                err_sel = ERR_FRAME;
            end else begin
                fcount_next = fcnt_inc;
                unique case (phase_reg)
                    PH_TYPE: begin
                        pcr_next   = 1'b0;
                        hneg_next  = 1'b0;
                        hval_next  = '0;
                        dend_next  = 1'b0;
                        phase_next = PH_HDR_FIRST;
                        if (s_data_byte == CHAR_BULK || s_data_byte == CHAR_VERB) begin
                            kind_next = KIND_BULK;
                        end else if (s_data_byte == CHAR_ARRAY || s_data_byte == CHAR_SET
                                     || s_data_byte == CHAR_PUSH) begin
                            kind_next = KIND_ARRAY;
                        end else if (s_data_byte == CHAR_MAP) begin
                            kind_next = KIND_MAP;
                        end else if (s_data_byte == CHAR_ATTR) begin
                            kind_next = KIND_ATTR;
                        end else begin
                            phase_next = PH_LINE;
                        end
                    end
                    PH_LINE: begin
                        if (pcr_reg && s_data_byte == CHAR_LF) begin
                            elem_done = 1'b1;
                        end else begin
                            pcr_next = (s_data_byte == CHAR_CR);
                        end
                    end
                    PH_HDR_FIRST: begin
                        if (s_data_byte == CHAR_MINUS) begin
                            hneg_next = 1'b1;
                        end else if (s_data_byte == CHAR_PLUS) begin
                            hneg_next = hneg_reg;
                        end else if (digit) begin
                            hval_next = COUNT_BITS'(dval);
                        end else begin
                            dend_next = 1'b1;
                        end
                        pcr_next   = (s_data_byte == CHAR_CR);
                        phase_next = PH_HDR_REST;
                    end
                    PH_HDR_REST: begin
                        if (pcr_reg && s_data_byte == CHAR_LF) begin
                            // Header complete: a nonzero negative value is a null element.
                            pcr_next = 1'b0;
                            if (hneg_reg && hval_reg != '0) begin
                                elem_done = 1'b1;
                            end else if (kind_reg == KIND_BULK) begin
                                pay_next   = {1'b0, hval_reg} + OWE_W'(2);
                                phase_next = PH_PAYLOAD;
                            end else if (owed == '0) begin
                                elem_done = 1'b1;
                            end else if (depth_reg >= DEPTH_W'(MAX_NEST_DEPTH)) begin
                                err_hit = 1'b1;
                                err_sel = ERR_NEST;
                            end else begin
                                stack_we    = 1'b1;
                                stack_waddr = depth_reg[IDX_W-1:0];
                                stack_wdata = owed;
                                depth_next  = depth_reg + DEPTH_W'(1);
                                phase_next  = PH_TYPE;
                            end
                        end else if (!dend_reg && digit) begin
                            if (|prod[PROD_W-1:COUNT_BITS]) begin
                                err_hit = 1'b1;
                                err_sel = ERR_HEADER;
                            end else begin
                                hval_next = prod[COUNT_BITS-1:0];
                                pcr_next  = 1'b0;
                            end
                        end else begin
                            dend_next = 1'b1;
                            pcr_next  = (s_data_byte == CHAR_CR);
                        end
                    end
                    PH_PAYLOAD: begin
                        if (pay_dec == '0) begin
                            elem_done = 1'b1;
                        end else begin
                            pay_next = pay_dec;
                        end
                    end
                    default: begin
                        restart_now = 1'b1;
                    end
                endcase
            end

            if (elem_done) begin
                phase_next = PH_TYPE;
                pcr_next   = 1'b0;
                if (depth_zero) begin
                    emit        = 1'b1;
                    len_next    = fcnt_inc;
                    err_next    = ERR_OK;
                    fcount_next = '0;
                end else begin
                    stack_we = 1'b1;
                    if (top_dec == '0) begin
                        depth_next  = top_full;
                        cascade_req = 1'b1;
                    end
                end
            end
        end else if (cmd.close_step) begin
            // One enclosing aggregate per cycle; the frame ends once none is left.
            if (depth_zero) begin
                emit        = 1'b1;
                len_next    = fcount_reg;
                err_next    = ERR_OK;
                fcount_next = '0;
            end else begin
                stack_we = 1'b1;
                if (top_dec == '0) begin
                    depth_next = top_full;
                end
            end
        end

        if (err_hit || restart_now) begin
            phase_next  = PH_TYPE;
            kind_next   = KIND_BULK;
            hneg_next   = 1'b0;
            hval_next   = '0;
            dend_next   = 1'b0;
            pcr_next    = 1'b0;
            pay_next    = '0;
            depth_next  = '0;
            fcount_next = '0;
            stack_we    = 1'b0;
            cascade_req = 1'b0;
        end
        if (err_hit) begin
            emit     = 1'b1;
            len_next = '0;
            err_next = err_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TYPE;
            kind_reg   <= KIND_BULK;
            hneg_reg   <= 1'b0;
            hval_reg   <= '0;
            dend_reg   <= 1'b0;
            pcr_reg    <= 1'b0;
            pay_reg    <= '0;
            depth_reg  <= '0;
            fcount_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            hneg_reg   <= hneg_next;
            hval_reg   <= hval_next;
            dend_reg   <= dend_next;
            pcr_reg    <= pcr_next;
            pay_reg    <= pay_next;
            depth_reg  <= depth_next;
            fcount_reg <= fcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        err_reg <= err_next;
        if (stack_we) begin
            stack_reg[stack_waddr] <= stack_wdata;
        end
    end

    assign status.emit        = emit;
    assign status.cascade_req = cascade_req;
    assign status.depth_zero  = depth_zero;
    assign status.close_last  = depth_zero || (top_owed != OWE_W'(1));

    assign m_frame_length = len_reg;
    assign m_error_code   = err_reg;

endmodule

// ----- rtl/rfbs_controller.sv -----
// Controller of the frame boundary scanner: handshakes on both channels and
// sequences the closing of nested aggregates. Depends on rfbs_pkg.
module rfbs_controller import rfbs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_RUN: begin
                if (cmd.take_byte && status.cascade_req) begin
                    state_next = CTRL_CLOSE;
                end
            end
            CTRL_CLOSE: begin
                if (cmd.close_step && status.close_last) begin
                    state_next = CTRL_RUN;
                end
            end
            default: begin
                state_next = CTRL_RUN;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.take_byte  = 1'b0;
        cmd.close_step = 1'b0;
        unique case (state_reg)
            CTRL_RUN: begin
                s_ready       = out_free;
                cmd.take_byte = s_valid && out_free;
            end
            CTRL_CLOSE: begin
                // A step that delivers the frame waits for a free output register.
                cmd.close_step = !status.depth_zero || out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (status.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTRL_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/resp_frame_boundary_scanner.sv -----
// Reply frame boundary scanner: one byte per cycle; a result transfer is
// offered in the cycle after the byte that completes a frame or raises an error.
// Each aggregate that closes with the element a byte completes takes a step in
// the close sequencer, during which no byte is taken; a frame that ends this way
// is offered after those steps. Bytes wait while the output register is full.
// Synchronous active-low reset restarts the parser; the nesting stack is not cleared.
module resp_frame_boundary_scanner import rfbs_pkg::*; #(
    parameter int MAX_NEST_DEPTH = MAX_NEST_DEPTH_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAME_BITS-1:0] m_frame_length,
    output logic [ERR_BITS-1:0]   m_error_code
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rfbs_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    rfbs_datapath #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .cmd            (cmd),
        .status         (status),
        .m_frame_length (m_frame_length),
        .m_error_code   (m_error_code)
    );

endmodule

// ----- rtl/rfbs_checker.sv -----
// Port-level checks for the frame boundary scanner, bound to the top level.
// Depends on rfbs_pkg.
module rfbs_checker import rfbs_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [FRAME_BITS-1:0] m_frame_length,
    input logic [ERR_BITS-1:0]   m_error_code
);

    // An error result always reports a length of zero.
    a_err_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_OK) |-> (m_frame_length == '0))
        else $error("error result with nonzero length");

    // The shortest complete frame is a type byte followed by CR LF.
    a_min_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == ERR_OK) |-> (m_frame_length >= FRAME_BITS'(3)))
        else $error("frame shorter than three bytes");

    // No byte is taken while a result waits and is not drained.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output is blocked");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind resp_frame_boundary_scanner rfbs_checker u_rfbs_checker (.*);
